FILE: hw/rtl/asr_pkg.sv
// ----------------------------------------------------------------------------
// asr_pkg
// Shared types and constants for the axis sum/mean reduction block.
// ----------------------------------------------------------------------------
package asr_pkg;

  localparam int SAMPLE_W = 16;
  localparam int LEN_W    = 11;
  localparam int SUM_W    = 27;
  localparam int RES_W    = 26;
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = 2;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_AXIS_LENGTH  = 2'd0;
  localparam logic [1:0] REG_INNER_STRIDE = 2'd1;
  localparam logic [1:0] REG_MEAN_MODE    = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_element;
  } in_item_t;

  typedef struct packed {
    logic signed [RES_W-1:0] reduced_value;
    logic                    last_result;
  } out_item_t;

  // Effective (clamped) shape and mode
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] stride;
    logic             mean;
  } shape_t;

  // One classified item waiting for the accumulate stage
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [LEN_W-1:0]           pos;
    logic                       first;
    logic                       emit;
    logic                       last;
  } q_entry_t;

endpackage

FILE: hw/rtl/asr_stream_if.sv
// ----------------------------------------------------------------------------
// asr_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface asr_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/axis_sum_mean_reduction.sv
// ----------------------------------------------------------------------------
// axis_sum_mean_reduction
// Streaming sum or truncated mean of a row-major tensor along one axis.
// ----------------------------------------------------------------------------
// Usage:
//   in_s carries Q8.8 samples in row-major order, last_element on the final
//   element of the tensor. out_s carries one reduced value per completed
//   axis slice, in output index order, last_result on the one caused by the
//   final element. The APB port sets axis_length (0x0), inner_stride (0x4)
//   and mean_mode (0x8); write them only while the block is idle.
//   A front stage classifies items and queues them four deep; the back stage
//   does a RAM read then a write per item, one item at a time, and passes
//   a mean through a shift-subtract divider before the result is offered.
//   The queue lets in_s take new items while the back stage is busy, until
//   the queue is full.
//   Reset clears positions and registers (axis_length 1, inner_stride 1, sum
//   mode); the partial-sum RAM needs no clearing pass. When the receiver
//   stalls, the result holds, the back stage waits and the queue fills
//   before in_s.ready drops.
// ----------------------------------------------------------------------------
module axis_sum_mean_reduction
  import asr_pkg::*;
#(
  parameter int MAX_STRIDE = 1024,
  parameter int MAX_AXIS   = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  asr_stream_if.sink   in_s,
  asr_stream_if.source out_s,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = (MAX_STRIDE > 1) ? $clog2(MAX_STRIDE) : 1;
  localparam int LEN_MAX = (1 << LEN_W) - 1;
  localparam logic [LEN_W-1:0] AXIS_CAP   =
    LEN_W'((MAX_AXIS < LEN_MAX) ? MAX_AXIS : LEN_MAX);
  localparam logic [LEN_W-1:0] STRIDE_CAP =
    LEN_W'((MAX_STRIDE < LEN_MAX) ? MAX_STRIDE : LEN_MAX);

  logic [LEN_W-1:0] axis_length_r, inner_stride_r;
  logic             mean_mode_r;
  logic             wr;
  logic [1:0]       idx;
  logic             pos_clear;
  shape_t           shape;
  logic             q_push, q_full, q_pop, q_valid;
  q_entry_t         q_in, q_out;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_length_r  <= LEN_W'(1);
      inner_stride_r <= LEN_W'(1);
      mean_mode_r    <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        REG_AXIS_LENGTH:  axis_length_r  <= pwdata[LEN_W-1:0];
        REG_INNER_STRIDE: inner_stride_r <= pwdata[LEN_W-1:0];
        REG_MEAN_MODE:    mean_mode_r    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (idx)
      REG_AXIS_LENGTH:  prdata = 32'(axis_length_r);
      REG_INNER_STRIDE: prdata = 32'(inner_stride_r);
      REG_MEAN_MODE:    prdata = 32'(mean_mode_r);
      default:          prdata = '0;
    endcase
  end

  // Clamp the shape to the supported range
  always_comb begin
    pos_clear = wr && ((idx == REG_AXIS_LENGTH) || (idx == REG_INNER_STRIDE));
    shape.len = (axis_length_r == '0) ? LEN_W'(1) :
                (axis_length_r > AXIS_CAP) ? AXIS_CAP : axis_length_r;
    shape.stride = (inner_stride_r == '0) ? LEN_W'(1) :
                   (inner_stride_r > STRIDE_CAP) ? STRIDE_CAP : inner_stride_r;
    shape.mean = mean_mode_r;
  end

  asr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (in_s),
    .shape     (shape),
    .pos_clear (pos_clear),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  asr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_out)
  );

  asr_back #(.MAX_STRIDE(MAX_STRIDE), .AW(AW)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .shape   (shape),
    .q_valid (q_valid),
    .q_data  (q_out),
    .q_pop   (q_pop),
    .out_s   (out_s)
  );

endmodule

FILE: hw/rtl/asr_ram.sv
// ----------------------------------------------------------------------------
// asr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module asr_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/asr_front.sv
// ----------------------------------------------------------------------------
// asr_front
// Accepts items, tracks stride and axis positions, and classifies each item.
// ----------------------------------------------------------------------------
module asr_front
  import asr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  asr_stream_if.sink in_s,
  input  shape_t   shape,
  input  logic     pos_clear,
  input  logic     q_full,
  output logic     q_push,
  output q_entry_t q_data
);

  logic [LEN_W-1:0] stride_pos_r, stride_pos_nxt;
  logic [LEN_W-1:0] axis_pos_r, axis_pos_nxt;
  logic [LEN_W-1:0] s, a;
  logic [LEN_W:0]   s_inc, a_inc;
  logic             axis_end, stride_end;

  assign in_s.ready = !q_full;
  assign q_push     = in_s.valid && !q_full;

  // Classify the current item
  always_comb begin
    s          = (stride_pos_r >= shape.stride) ? '0 : stride_pos_r;
    a          = (axis_pos_r >= shape.len) ? '0 : axis_pos_r;
    s_inc      = {1'b0, s} + 1'b1;
    a_inc      = {1'b0, a} + 1'b1;
    axis_end   = (a_inc >= {1'b0, shape.len});
    stride_end = (s_inc >= {1'b0, shape.stride});

    q_data.sample = in_s.payload.sample;
    q_data.pos    = s;
    q_data.first  = (a == '0);
    q_data.emit   = axis_end;
    q_data.last   = in_s.payload.last_element;

    stride_pos_nxt = stride_pos_r;
    axis_pos_nxt   = axis_pos_r;
    if (pos_clear) begin
      stride_pos_nxt = '0;
      axis_pos_nxt   = '0;
    end else if (q_push) begin
      if (in_s.payload.last_element) begin
        stride_pos_nxt = '0;
        axis_pos_nxt   = '0;
      end else if (stride_end) begin
        stride_pos_nxt = '0;
        axis_pos_nxt   = axis_end ? '0 : a_inc[LEN_W-1:0];
      end else begin
        stride_pos_nxt = s_inc[LEN_W-1:0];
        axis_pos_nxt   = a;
      end
    end
  end

  // Hold positions
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_pos_r <= '0;
      axis_pos_r   <= '0;
    end else begin
      stride_pos_r <= stride_pos_nxt;
      axis_pos_r   <= axis_pos_nxt;
    end
  end

endmodule

FILE: hw/rtl/asr_queue.sv
// ----------------------------------------------------------------------------
// asr_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module asr_queue
  import asr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     valid,
  output q_entry_t pop_data
);

  q_entry_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QPTR_W:0]   count_r;

  assign full     = (count_r == (QPTR_W+1)'(QDEPTH));
  assign valid    = (count_r != '0);
  assign pop_data = mem_r[rptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
      count_r <= count_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

endmodule

FILE: hw/rtl/asr_back.sv
// ----------------------------------------------------------------------------
// asr_back
// Accumulates items into the partial-sum RAM, divides for the mean and emits.
// ----------------------------------------------------------------------------
module asr_back
  import asr_pkg::*;
#(
  parameter int MAX_STRIDE = 1024,
  parameter int AW         = 10
) (
  input  logic     clk,
  input  logic     rst_n,
  input  shape_t   shape,
  input  logic     q_valid,
  input  q_entry_t q_data,
  output logic     q_pop,
  asr_stream_if.source out_s
);

  typedef enum logic [2:0] {S_IDLE, S_ACC, S_DIV, S_FIN, S_OUT} state_t;

  state_t           state_r;
  q_entry_t         ent_r;
  logic [SUM_W-1:0] quo_r;
  logic [LEN_W-1:0] rem_r;
  logic [4:0]       cnt_r;
  logic             neg_r;
  logic [RES_W-1:0] res_r;
  logic             res_last_r;

  logic                    ram_we;
  logic [SUM_W-1:0]        rdata;
  logic signed [SUM_W-1:0] sum;
  logic [SUM_W-1:0]        sum_mag;
  logic [LEN_W:0]          trial;
  logic                    fits;
  logic [SUM_W-1:0]        quo_neg;

  asr_ram #(.WIDTH(SUM_W), .DEPTH(MAX_STRIDE), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(ent_r.pos)),
    .wdata (sum),
    .re    (q_pop),
    .raddr (AW'(q_data.pos)),
    .rdata (rdata)
  );

  // Accumulate and one restoring division step
  always_comb begin
    sum = ent_r.first ? SUM_W'(ent_r.sample)
                      : $signed(rdata) + SUM_W'(ent_r.sample);
    sum_mag = sum[SUM_W-1] ? SUM_W'(-sum) : sum;
    trial   = {rem_r, quo_r[SUM_W-1]};
    fits    = (trial >= {1'b0, shape.len});
    quo_neg = SUM_W'(-quo_r);
    q_pop   = (state_r == S_IDLE) && q_valid;
    ram_we  = (state_r == S_ACC);
  end

  assign out_s.valid                 = (state_r == S_OUT);
  assign out_s.payload.reduced_value = res_r;
  assign out_s.payload.last_result   = res_last_r;

  // Sequence one item at a time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            ent_r   <= q_data;
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          res_last_r <= ent_r.last;
          if (!ent_r.emit) begin
            state_r <= S_IDLE;
          end else if (shape.mean) begin
            neg_r   <= sum[SUM_W-1];
            quo_r   <= sum_mag;
            rem_r   <= '0;
            cnt_r   <= 5'(SUM_W-1);
            state_r <= S_DIV;
          end else begin
            res_r   <= sum[RES_W-1:0];
            state_r <= S_OUT;
          end
        end
        S_DIV: begin
          rem_r <= fits ? LEN_W'(trial - {1'b0, shape.len}) : trial[LEN_W-1:0];
          quo_r <= {quo_r[SUM_W-2:0], fits};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) state_r <= S_FIN;
        end
        S_FIN: begin
          res_r   <= neg_r ? quo_neg[RES_W-1:0] : quo_r[RES_W-1:0];
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_s.ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: dv/axis_sum_mean_reduction_tb.sv
// ----------------------------------------------------------------------------
// axis_sum_mean_reduction_tb
// Drives row-major Q8.8 tensors through the reduction block under several
// axis lengths, strides and modes, predicts every sum or truncated mean in
// the testbench, and checks each result item in order as it is accepted.
// ----------------------------------------------------------------------------
module axis_sum_mean_reduction_tb;
  import asr_pkg::*;

  localparam int MAX_LEN    = 1024;
  localparam int IDLE_LIMIT = 3000;
  localparam int SETTLE_CYC = 100;
  localparam int HOLD_CYC   = 300;
  localparam int RAND_ITEMS = 230;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  asr_stream_if #(.payload_t(in_item_t))  in_if ();
  asr_stream_if #(.payload_t(out_item_t)) out_if ();

  axis_sum_mean_reduction i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_s   (in_if),
    .out_s  (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Predictor state: raw registers, positions and running sums
  logic [LEN_W-1:0] axis_len_reg;
  logic [LEN_W-1:0] stride_reg;
  logic             mean_reg;
  int               stride_pos;
  int               axis_pos;
  int               running_sums [MAX_LEN];

  out_item_t expected_results [$];

  int  mismatches;
  int  idle_cycles;
  int  hold_left;
  int  stall_left;
  bit  idle_on;
  bit  in_fire;
  bit  out_fire;

  always #5 clk = ~clk;

  // Clamp a raw length register to 1..MAX_LEN
  function automatic int eff_len(logic [LEN_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_LEN) return MAX_LEN;
    return int'(v);
  endfunction

  // Advance the reduction by one item and queue the result it causes
  task automatic predict_reduction(in_item_t it);
    int        len;
    int        str;
    int        s;
    int        v;
    out_item_t r;
    len = eff_len(axis_len_reg);
    str = eff_len(stride_reg);
    s   = stride_pos;
    if (s >= str) s = 0;
    if (axis_pos >= len) axis_pos = 0;
    if (axis_pos == 0) running_sums[s] = int'(it.sample);
    else running_sums[s] += int'(it.sample);
    if (axis_pos + 1 >= len) begin
      v = running_sums[s];
      if (mean_reg) v = v / len;
      r.reduced_value = v[RES_W-1:0];
      r.last_result   = it.last_element;
      expected_results.push_back(r);
    end
    if (it.last_element) begin
      stride_pos = 0;
      axis_pos   = 0;
    end else if (s + 1 >= str) begin
      stride_pos = 0;
      axis_pos   = (axis_pos + 1 >= len) ? 0 : axis_pos + 1;
    end else begin
      stride_pos = s + 1;
    end
  endtask

  // Drop valid, wait until every expected result has come, then settle
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_AXIS_LENGTH) begin
      axis_len_reg = val[LEN_W-1:0];
      stride_pos   = 0;
      axis_pos     = 0;
    end else if (idx == REG_INNER_STRIDE) begin
      stride_reg = val[LEN_W-1:0];
      stride_pos = 0;
      axis_pos   = 0;
    end else if (idx == REG_MEAN_MODE) begin
      mean_reg = val[0];
    end
  endtask

  task automatic set_shape(int len, int str, bit mean);
    wait_drained();
    write_reg(REG_AXIS_LENGTH, len);
    write_reg(REG_INNER_STRIDE, str);
    write_reg(REG_MEAN_MODE, 32'(mean));
  endtask

  // Offer one item and hold it until accepted
  task automatic send_item(logic signed [SAMPLE_W-1:0] smp, bit last);
    in_item_t it;
    it.sample       = smp;
    it.last_element = last;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= it;
    do @(posedge clk); while (!in_if.ready);
    predict_reduction(it);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return 16'($urandom());
    endcase
  endfunction

  // Check each accepted result and drive ready
  always @(posedge clk) begin
    out_item_t want;
    out_fire = out_if.valid && out_if.ready;
    if (out_fire) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %0d last %0b",
                   out_if.payload.reduced_value, out_if.payload.last_result);
      end else begin
        want = expected_results.pop_front();
        if (want.reduced_value !== out_if.payload.reduced_value ||
            want.last_result !== out_if.payload.last_result) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected value %0d last %0b, got value %0d last %0b",
                     want.reduced_value, want.last_result,
                     out_if.payload.reduced_value, out_if.payload.last_result);
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Watchdog on cycles with no accepted item on either channel
  always @(posedge clk) begin
    in_fire = in_if.valid && in_if.ready;
    if (in_fire || (out_if.valid && out_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Extreme samples, early end, truncation of negative means
  task automatic test_directed();
    set_shape(2, 2, 1'b0);
    send_item(16'sh7fff, 0);
    send_item(16'sh8000, 0);
    send_item(16'sh7fff, 0);
    send_item(16'sh8000, 1);
    send_item(16'sh0100, 0);
    send_item(16'sh0001, 1);
    set_shape(3, 1, 1'b1);
    send_item(-16'sd1, 0);
    send_item(-16'sd1, 0);
    send_item(16'sd0, 0);
    send_item(16'sd7, 0);
    send_item(16'sd1, 0);
    send_item(-16'sd5, 1);
    send_item(16'sd4, 0);
    send_item(-16'sd9, 0);
    send_item(16'sd2, 1);
    wait_drained();
    write_reg(REG_MEAN_MODE, 0);
    send_item(16'sd3, 0);
    send_item(16'sd3, 0);
    send_item(16'sd3, 1);
  endtask

  // Out-of-range lengths clamp to 1 and to the maximum
  task automatic test_range_clamp();
    set_shape(0, 0, 1'b0);
    for (int i = 0; i < 6; i++) send_item(rand_sample(), i == 5);
    set_shape(1, 2047, 1'b1);
    for (int i = 0; i < 40; i++) send_item(rand_sample(), i == 39);
  endtask

  // Longest axis: most negative sum, then an early end of a long mean axis
  task automatic test_full_axis();
    set_shape(2047, 1, 1'b0);
    for (int i = 0; i < MAX_LEN; i++) send_item(16'sh8000, i == MAX_LEN - 1);
    set_shape(MAX_LEN, 1, 1'b1);
    for (int i = 0; i < 24; i++) send_item(rand_sample(), i == 23);
  endtask

  // Long receiver hold while the sender keeps offering items
  task automatic test_backpressure();
    set_shape(1, 3, 1'b0);
    hold_left = HOLD_CYC;
    for (int i = 0; i < 40; i++) send_item(rand_sample(), i == 39);
    in_if.valid <= 1'b0;
    wait_drained();
  endtask

  // Random shapes and tensors, mostly well formed
  task automatic test_random();
    int sent;
    int len;
    int str;
    int n;
    int cut;
    int kind;
    sent = 0;
    while (sent < RAND_ITEMS) begin
      if (sent > RAND_ITEMS - 80) idle_on = 1'b0;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        wait_drained();
        write_reg(REG_MEAN_MODE, $urandom_range(0, 1));
      end else if (kind < 4) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) * 2047 : $urandom_range(1, 6);
        str = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
        set_shape(len, str, 1'($urandom_range(0, 1)));
      end
      n   = eff_len(axis_len_reg) * eff_len(stride_reg);
      if (n > 64) n = $urandom_range(1, 64);
      kind = $urandom_range(0, 9);
      cut = (kind == 0) ? $urandom_range(1, n) : n;
      for (int i = 0; i < cut; i++) begin
        send_item(rand_sample(), (kind != 1) && (i == cut - 1));
        sent++;
      end
    end
    in_if.valid <= 1'b0;
  endtask

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_if.valid  = 1'b0;
    in_if.payload = '0;
    out_if.ready = 1'b0;
    axis_len_reg = 1;
    stride_reg   = 1;
    mean_reg     = 1'b0;
    stride_pos   = 0;
    axis_pos     = 0;
    mismatches   = 0;
    idle_cycles  = 0;
    hold_left    = 0;
    stall_left   = 0;
    idle_on      = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_range_clamp();
    test_full_axis();
    test_backpressure();
    test_random();
    wait_drained();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: axis_sum_mean_reduction.f
hw/rtl/asr_pkg.sv
hw/rtl/asr_stream_if.sv
hw/rtl/asr_ram.sv
hw/rtl/asr_front.sv
hw/rtl/asr_queue.sv
hw/rtl/asr_back.sv
hw/rtl/axis_sum_mean_reduction.sv
dv/axis_sum_mean_reduction_tb.sv
